// ===== design/bfg_pkg.sv =====
// Package for the battery fuel gauge: sizes, register indexes, controller states,
// command and status types and the saturating 64-bit add.
// It depends on nothing; every design file takes names from it by scope.
package bfg_pkg;

  localparam int BarPixels = 156;
  localparam int BarW      = $clog2(BarPixels + 1);
  localparam int NumW      = 16 + BarW;
  localparam int CntW      = $clog2(NumW);
  localparam int InW       = 48;
  localparam int OutW      = 208;

  localparam logic [2:0] CfgFull  = 3'd0;
  localparam logic [2:0] CfgGood  = 3'd1;
  localparam logic [2:0] CfgHalf  = 3'd2;
  localparam logic [2:0] CfgLow   = 3'd3;
  localparam logic [2:0] CfgEmpty = 3'd4;
  localparam logic [2:0] CfgLoad  = 3'd5;

  localparam logic [15:0] FullReset  = 16'd10160;
  localparam logic [15:0] GoodReset  = 16'd9960;
  localparam logic [15:0] HalfReset  = 16'd9760;
  localparam logic [15:0] LowReset   = 16'd9600;
  localparam logic [15:0] EmptyReset = 16'd9440;
  localparam logic [15:0] LoadReset  = 16'd400;

  localparam logic [1:0] LevelGood  = 2'd0;
  localparam logic [1:0] LevelHalf  = 2'd1;
  localparam logic [1:0] LevelLow   = 2'd2;
  localparam logic [1:0] LevelBelow = 2'd3;

  typedef enum logic [2:0] {
    S_IDLE,
    S_POWER,
    S_CHARGE,
    S_ENERGY,
    S_DIVIDE,
    S_FINISH
  } state_t;

  typedef enum logic [1:0] {
    OP_NONE,
    OP_POWER,
    OP_CHARGE,
    OP_ENERGY
  } mul_op_t;

  typedef struct packed {
    logic    load;
    mul_op_t mul_op;
    logic    div_step;
    logic    out_load;
  } cmd_t;

  typedef struct packed {
    logic div_done;
  } status_t;

  function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                 input logic signed [63:0] b);
    logic signed [63:0] sum;
    sum = a + b;
    if ((a[63] == b[63]) && (sum[63] != a[63])) begin
      sum = a[63] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    end
    return sum;
  endfunction

endpackage

// ===== design/battery_fuel_gauge.sv =====
// Battery fuel gauge top level: coulomb and energy counting with voltage bands.
// Joins bfg_ctrl and bfg_datapath; uses bfg_pkg.
// A request is taken only when the block is idle. It runs three steps of the shared
// multiplier and one bar divider step per numerator bit (24 for a 156-pixel bar),
// then the output load, which waits while an earlier result is still stalled.
// Synchronous reset restores the register defaults and clears both running sums.
module battery_fuel_gauge (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     s_axis_tvalid,
  output logic                     s_axis_tready,
  // Fields from bit 0: bus_code, shunt_code, elapsed_ms.
  input  logic [bfg_pkg::InW-1:0]  s_axis_tdata,
  output logic                     m_axis_tvalid,
  input  logic                     m_axis_tready,
  // Fields from bit 0: bus_out, shunt_out, power_product, charge_total,
  // energy_total, level, under_load, bar_width, then zero fill.
  output logic [bfg_pkg::OutW-1:0] m_axis_tdata,
  input  logic                     cfg_we,
  input  logic [2:0]               cfg_index,
  input  logic [15:0]              cfg_data
);

  bfg_pkg::cmd_t    cmd;
  bfg_pkg::status_t status;

  bfg_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .status    (status),
    .cmd       (cmd)
  );

  bfg_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (s_axis_tdata),
    .cmd       (cmd),
    .status    (status),
    .out_data  (m_axis_tdata)
  );

endmodule

// ===== design/bfg_ctrl.sv =====
// Controller of the fuel gauge: sequences the shared multiplier, the bar divider
// and the output register. Uses bfg_pkg for states, commands and status.
module bfg_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  input  bfg_pkg::status_t status,
  output bfg_pkg::cmd_t    cmd
);

  bfg_pkg::state_t state, state_next;
  logic            out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= bfg_pkg::S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next   = state;
    cmd.load     = 1'b0;
    cmd.mul_op   = bfg_pkg::OP_NONE;
    cmd.div_step = 1'b0;
    cmd.out_load = 1'b0;
    in_ready     = 1'b0;
    case (state)
      bfg_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = bfg_pkg::S_POWER;
        end
      end
      bfg_pkg::S_POWER: begin
        cmd.mul_op = bfg_pkg::OP_POWER;
        state_next = bfg_pkg::S_CHARGE;
      end
      bfg_pkg::S_CHARGE: begin
        cmd.mul_op = bfg_pkg::OP_CHARGE;
        state_next = bfg_pkg::S_ENERGY;
      end
      bfg_pkg::S_ENERGY: begin
        cmd.mul_op = bfg_pkg::OP_ENERGY;
        state_next = bfg_pkg::S_DIVIDE;
      end
      bfg_pkg::S_DIVIDE: begin
        cmd.div_step = 1'b1;
        if (status.div_done) begin
          state_next = bfg_pkg::S_FINISH;
        end
      end
      bfg_pkg::S_FINISH: begin
        if (!out_valid || out_ready) begin
          cmd.out_load = 1'b1;
          state_next   = bfg_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = bfg_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.out_load) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

endmodule

// ===== design/bfg_datapath.sv =====
// Datapath of the fuel gauge: configuration registers, shared signed multiplier,
// saturating accumulators, restoring bar divider and output register. Uses bfg_pkg.
module bfg_datapath (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_we,
  input  logic [2:0]               cfg_index,
  input  logic [15:0]              cfg_data,
  input  logic [bfg_pkg::InW-1:0]  in_data,
  input  bfg_pkg::cmd_t            cmd,
  output bfg_pkg::status_t         status,
  output logic [bfg_pkg::OutW-1:0] out_data
);

  logic [15:0] full_level, good_level, half_level, low_level, empty_level;
  logic [15:0] load_threshold;

  logic [15:0]        bus_r;
  logic signed [15:0] shunt_r;
  logic [15:0]        ms_r;
  logic signed [31:0] power_r;
  logic signed [63:0] charge_acc, energy_acc;

  logic [bfg_pkg::NumW-1:0] num_r, quo_r;
  logic [16:0]              rem_r;
  logic [15:0]              den_r;
  logic                     bar_ok;
  logic [bfg_pkg::CntW-1:0] cnt;

  logic signed [32:0] mul_a;
  logic signed [16:0] mul_b;
  logic signed [49:0] prod;
  logic signed [63:0] inc;

  logic [16:0]              rem_sh;
  logic [bfg_pkg::NumW-1:0] num_load;
  logic [bfg_pkg::NumW-1:0] bar_clamp;
  logic [1:0]               level;
  logic [16:0]              mag;
  logic                     under_load;
  logic [7:0]               bar_width;

  always_ff @(posedge clk) begin
    if (rst) begin
      full_level     <= bfg_pkg::FullReset;
      good_level     <= bfg_pkg::GoodReset;
      half_level     <= bfg_pkg::HalfReset;
      low_level      <= bfg_pkg::LowReset;
      empty_level    <= bfg_pkg::EmptyReset;
      load_threshold <= bfg_pkg::LoadReset;
    end else if (cfg_we) begin
      case (cfg_index)
        bfg_pkg::CfgFull:  full_level     <= cfg_data;
        bfg_pkg::CfgGood:  good_level     <= cfg_data;
        bfg_pkg::CfgHalf:  half_level     <= cfg_data;
        bfg_pkg::CfgLow:   low_level      <= cfg_data;
        bfg_pkg::CfgEmpty: empty_level    <= cfg_data;
        bfg_pkg::CfgLoad:  load_threshold <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cmd.mul_op)
      bfg_pkg::OP_POWER: begin
        mul_a = {17'd0, bus_r};
        mul_b = {shunt_r[15], shunt_r};
      end
      bfg_pkg::OP_CHARGE: begin
        mul_a = {{17{shunt_r[15]}}, shunt_r};
        mul_b = {1'b0, ms_r};
      end
      bfg_pkg::OP_ENERGY: begin
        mul_a = {power_r[31], power_r};
        mul_b = {1'b0, ms_r};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    prod = mul_a * mul_b;
    inc  = {{14{prod[49]}}, prod};
  end

  assign num_load = bfg_pkg::NumW'(in_data[15:0] - empty_level)
                  * bfg_pkg::NumW'(bfg_pkg::BarPixels);
  assign rem_sh   = {rem_r[15:0], num_r[bfg_pkg::NumW-1]};
  assign status.div_done = (cnt == bfg_pkg::CntW'(bfg_pkg::NumW - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      charge_acc <= '0;
      energy_acc <= '0;
    end else begin
      case (cmd.mul_op)
        bfg_pkg::OP_CHARGE: charge_acc <= bfg_pkg::sat_add(charge_acc, inc);
        bfg_pkg::OP_ENERGY: energy_acc <= bfg_pkg::sat_add(energy_acc, inc);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      bus_r   <= in_data[15:0];
      shunt_r <= in_data[31:16];
      ms_r    <= in_data[47:32];
      num_r   <= num_load;
      den_r   <= full_level - empty_level;
      bar_ok  <= (full_level > empty_level) && (in_data[15:0] > empty_level);
      rem_r   <= '0;
      quo_r   <= '0;
      cnt     <= '0;
    end else if (cmd.div_step) begin
      num_r <= {num_r[bfg_pkg::NumW-2:0], 1'b0};
      cnt   <= cnt + 1'b1;
      if (rem_sh >= {1'b0, den_r}) begin
        rem_r <= rem_sh - {1'b0, den_r};
        quo_r <= {quo_r[bfg_pkg::NumW-2:0], 1'b1};
      end else begin
        rem_r <= rem_sh;
        quo_r <= {quo_r[bfg_pkg::NumW-2:0], 1'b0};
      end
    end
    if (cmd.mul_op == bfg_pkg::OP_POWER) begin
      power_r <= prod[31:0];
    end
  end

  always_comb begin
    if (bus_r >= good_level) begin
      level = bfg_pkg::LevelGood;
    end else if (bus_r >= half_level) begin
      level = bfg_pkg::LevelHalf;
    end else if (bus_r >= low_level) begin
      level = bfg_pkg::LevelLow;
    end else begin
      level = bfg_pkg::LevelBelow;
    end
    mag        = shunt_r[15] ? 17'd0 - {shunt_r[15], shunt_r} : {1'b0, shunt_r};
    under_load = mag > {1'b0, load_threshold};
    if (quo_r > bfg_pkg::NumW'(bfg_pkg::BarPixels)) begin
      bar_clamp = bfg_pkg::NumW'(bfg_pkg::BarPixels);
    end else begin
      bar_clamp = quo_r;
    end
    bar_width = bar_ok ? bar_clamp[7:0] : 8'd0;
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data <= {5'd0, bar_width, under_load, level, energy_acc, charge_acc,
                   power_r, shunt_r, bus_r};
    end
  end

endmodule

// ===== design/bfg_checker.sv =====
// Port-level checks for the battery fuel gauge, bound to the top level.
// Uses bfg_pkg for the bar length limit.
module bfg_checker (
  input logic                     clk,
  input logic                     rst,
  input logic                     s_axis_tvalid,
  input logic                     s_axis_tready,
  input logic                     m_axis_tvalid,
  input logic                     m_axis_tready,
  input logic [bfg_pkg::OutW-1:0] m_axis_tdata
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed or vanished");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready ##1 !s_axis_tready)
    else $error("request taken while the previous one is in work");

  a_reset_state: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid && s_axis_tready)
    else $error("block not idle after reset");

  a_bar_clamped: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (bfg_pkg::BarPixels < 256) |->
      m_axis_tdata[202:195] <= 8'(bfg_pkg::BarPixels))
    else $error("bar length beyond its clamp");

endmodule

bind battery_fuel_gauge bfg_checker u_bfg_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
